/* design/fec_pkg.sv */
// Shared types, codes and constants of the encoder frame check and freshness core.
// Depends on nothing; every other design file refers to it by scoped names.
package fec_pkg;

  localparam int ANGLE_BITS_DEF = 14;
  localparam int AGE_BITS_DEF   = 16;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 4;
  localparam int CRC_BITS    = 6;
  localparam int PP_BITS     = 6;
  localparam int COUNT_BITS  = 32;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CRC_BITS-1:0]    CRC_POLY   = 6'h03;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD = 4'hB;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SAMPLE_AGE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAIR_COUNT     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ANGLE_OFFSET   = 2'd2;

  typedef enum logic [OP_BITS-1:0] {
    OP_FRAME_DONE = 3'd0,
    OP_XFER_ERROR = 3'd1,
    OP_TICK       = 3'd2,
    OP_START      = 3'd3,
    OP_STOP       = 3'd4
  } op_t;

  typedef struct packed {
    logic                   good;
    logic [STATUS_BITS-1:0] status;
  } frame_chk_t;

  // x^k mod (x^6 + x + 1): CRC contribution of a single set message bit.
  function automatic logic [CRC_BITS-1:0] crc_col(input int unsigned k);
    logic [CRC_BITS-1:0] r;
    r = CRC_BITS'(1);
    for (int unsigned j = 0; j < k; j++) begin
      r = {r[CRC_BITS-2:0], 1'b0} ^ (r[CRC_BITS-1] ? CRC_POLY : '0);
    end
    return r;
  endfunction

endpackage

/* design/fec_in_if.sv */
// Input channel of the frame check core: event code and received frame word.
// Depends on fec_pkg for field widths.
interface fec_in_if #(
  parameter int ANGLE_BITS = fec_pkg::ANGLE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [fec_pkg::OP_BITS-1:0]      operation;
  logic [ANGLE_BITS+9:0]            frame_word;

  modport source (output valid, operation, frame_word, input ready);
  modport sink   (input valid, operation, frame_word, output ready);
endinterface

/* design/fec_out_if.sv */
// Result channel of the frame check core: event flags, health, status, angle, age and counter outputs.
// Depends on fec_pkg for field widths.
interface fec_out_if #(
  parameter int ANGLE_BITS = fec_pkg::ANGLE_BITS_DEF,
  parameter int AGE_BITS   = fec_pkg::AGE_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               request_transfer;
  logic                               frame_accepted;
  logic                               frame_rejected;
  logic                               healthy;
  logic [ANGLE_BITS-1:0]              angle_code;
  logic [fec_pkg::STATUS_BITS-1:0]    status_bits;
  logic signed [ANGLE_BITS:0]         mech_angle;
  logic signed [ANGLE_BITS+6:0]       elec_pos;
  logic [AGE_BITS-1:0]                sample_age;
  logic [fec_pkg::COUNT_BITS-1:0]     sample_count;
  logic [fec_pkg::COUNT_BITS-1:0]     error_count;

  modport source (output valid, request_transfer, frame_accepted, frame_rejected, healthy,
                  angle_code, status_bits, mech_angle, elec_pos, sample_age,
                  sample_count, error_count, input ready);
  modport sink   (input valid, request_transfer, frame_accepted, frame_rejected, healthy,
                  angle_code, status_bits, mech_angle, elec_pos, sample_age,
                  sample_count, error_count, output ready);
endinterface

/* design/fec_frame_chk.sv */
// Frame checker: CRC-6 over angle and status, pattern and status checks.
// Depends on fec_pkg for the polynomial, status mask and result struct.
module fec_frame_chk #(
  parameter int ANGLE_BITS = fec_pkg::ANGLE_BITS_DEF
) (
  input  logic [ANGLE_BITS+9:0] frame_word,
  output fec_pkg::frame_chk_t   chk
);

  localparam int FRAME_BITS = ANGLE_BITS + 10;
  localparam int DATA_BITS  = ANGLE_BITS + fec_pkg::STATUS_BITS;
  localparam int CB         = fec_pkg::CRC_BITS;

  logic [DATA_BITS-1:0] data;
  logic [CB-1:0]        term [DATA_BITS];
  logic [CB-1:0]        crc;
  logic [fec_pkg::STATUS_BITS-1:0] status;

  assign data   = frame_word[FRAME_BITS-1:CB];
  assign status = frame_word[CB+fec_pkg::STATUS_BITS-1:CB];

  // CRC is linear with zero start: XOR the column of every set bit.
  for (genvar gi = 0; gi < DATA_BITS; gi++) begin : g_col
    localparam logic [CB-1:0] COL = fec_pkg::crc_col(gi + CB);
    assign term[gi] = data[gi] ? COL : '0;
  end

  always_comb begin
    crc = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      crc = crc ^ term[i];
    end
  end

  always_comb begin
    chk.status = status;
    chk.good   = (frame_word != '0) && (frame_word != '1) &&
                 (crc == frame_word[CB-1:0]) &&
                 ((status & fec_pkg::STATUS_BAD) == '0);
  end

endmodule

/* design/encoder_frame_check_and_freshness_core.sv */
// Top level of the encoder frame check and freshness core.
// Depends on fec_pkg, fec_in_if, fec_out_if and fec_frame_chk.
//
// Usage:
//   in_if carries one event word per handshake: an operation code (frame done,
//   transfer error, service tick, start, stop) and, for frame done, the
//   received frame. out_if returns exactly one result word per event: event
//   flags, health, stored angle, status, mechanical and electrical angle,
//   sample age and the two counters, all taken after the event's update.
//   cfg_we/cfg_index/cfg_data write max_sample_age, pair_count, angle_offset;
//   write them only while no event is in flight.
// Path: input register, then one pass of check, state update and multiply
//   into the result register.
// Throughput: one word per cycle while out_if.ready is high or the result
//   register is empty; the one-pass update path sets the rate.
// Reset (rst_n low, synchronous): stopped, no sample, age all ones,
//   counters zero, configuration back to 3 / 1 / 0, both stages empty.
// Stall: when a result waits and out_if.ready is low the result register holds;
//   an empty input register still takes one more word, after which in_if.ready drops.
module encoder_frame_check_and_freshness_core #(
  parameter int ANGLE_BITS = fec_pkg::ANGLE_BITS_DEF,
  parameter int AGE_BITS   = fec_pkg::AGE_BITS_DEF,
  localparam int CFG_W = (AGE_BITS > ANGLE_BITS) ?
                         ((AGE_BITS > fec_pkg::PP_BITS) ? AGE_BITS : fec_pkg::PP_BITS) :
                         ((ANGLE_BITS > fec_pkg::PP_BITS) ? ANGLE_BITS : fec_pkg::PP_BITS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fec_in_if.sink                            in_if,
  fec_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [fec_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data
);

  localparam int A  = ANGLE_BITS;
  localparam int SB = fec_pkg::STATUS_BITS;
  localparam int CB = fec_pkg::CRC_BITS;
  localparam int PB = fec_pkg::PP_BITS;
  localparam int NB = fec_pkg::COUNT_BITS;
  localparam logic [A:0]          TURN_V = (A+1)'(1) << A;
  localparam logic [A:0]          HALF_V = (A+1)'(1) << (A-1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Configuration registers.
  logic [AGE_BITS-1:0] max_age_r;
  logic [PB-1:0]       pair_count_r;
  logic [A-1:0]        offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r    <= AGE_BITS'(3);
      pair_count_r <= PB'(1);
      offset_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fec_pkg::CFG_MAX_SAMPLE_AGE: max_age_r    <= cfg_data[AGE_BITS-1:0];
        fec_pkg::CFG_PAIR_COUNT:     pair_count_r <= cfg_data[PB-1:0];
        fec_pkg::CFG_ANGLE_OFFSET:   offset_r     <= cfg_data[A-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic               s1_valid_r;
  fec_pkg::op_t       s1_op_r;
  logic [A+9:0]       s1_frame_r;
  logic               out_valid_r;
  logic               advance;
  logic               fire;

  assign advance     = !out_valid_r || out_if.ready;
  assign fire        = s1_valid_r && advance;
  assign in_if.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_op_r    <= fec_pkg::op_t'(in_if.operation);
      s1_frame_r <= in_if.frame_word;
    end
  end

  fec_pkg::frame_chk_t chk;

  fec_frame_chk #(.ANGLE_BITS(A)) u_chk (
    .frame_word (s1_frame_r),
    .chk        (chk)
  );

  // Tracker state.
  logic            running_r, running_nxt;
  logic            busy_r, busy_nxt;
  logic            present_r, present_nxt;
  logic [SB-1:0]   status_r, status_nxt;
  logic [AGE_BITS-1:0] age_r, age_nxt;
  logic [A-1:0]    angle_r, angle_nxt;
  logic [NB-1:0]   good_r, good_nxt;
  logic [NB-1:0]   bad_r, bad_nxt;
  logic            req_nxt, acc_nxt, rej_nxt;

  always_comb begin
    running_nxt = running_r;
    busy_nxt    = busy_r;
    present_nxt = present_r;
    status_nxt  = status_r;
    age_nxt     = age_r;
    angle_nxt   = angle_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;
    req_nxt     = 1'b0;
    acc_nxt     = 1'b0;
    rej_nxt     = 1'b0;
    case (s1_op_r)
      fec_pkg::OP_FRAME_DONE: begin
        busy_nxt   = 1'b0;
        status_nxt = chk.status;
        if (chk.good) begin
          angle_nxt   = s1_frame_r[A+9:SB+CB];
          age_nxt     = '0;
          present_nxt = 1'b1;
          good_nxt    = good_r + NB'(1);
          acc_nxt     = 1'b1;
        end else begin
          bad_nxt = bad_r + NB'(1);
          rej_nxt = 1'b1;
        end
      end
      fec_pkg::OP_XFER_ERROR: begin
        busy_nxt = 1'b0;
        bad_nxt  = bad_r + NB'(1);
        rej_nxt  = 1'b1;
      end
      fec_pkg::OP_TICK: begin
        if (running_r) begin
          // Age only while a sample is held; saturate at all ones.
          if (present_r && age_r != AGE_MAX) begin
            age_nxt = age_r + AGE_BITS'(1);
          end
          req_nxt  = !busy_r;
          busy_nxt = 1'b1;
        end
      end
      fec_pkg::OP_START: begin
        if (!running_r) begin
          running_nxt = 1'b1;
          present_nxt = 1'b0;
          age_nxt     = AGE_MAX;
          busy_nxt    = 1'b1;
          req_nxt     = 1'b1;
        end
      end
      fec_pkg::OP_STOP: begin
        running_nxt = 1'b0;
        busy_nxt    = 1'b0;
        present_nxt = 1'b0;
        age_nxt     = AGE_MAX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      busy_r    <= 1'b0;
      present_r <= 1'b0;
      status_r  <= '0;
      age_r     <= AGE_MAX;
      angle_r   <= '0;
      good_r    <= '0;
      bad_r     <= '0;
    end else if (fire) begin
      running_r <= running_nxt;
      busy_r    <= busy_nxt;
      present_r <= present_nxt;
      status_r  <= status_nxt;
      age_r     <= age_nxt;
      angle_r   <= angle_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
    end
  end

  // Angle outputs from the updated stored angle: reverse direction; mech wraps to half
  // a turn, elec subtracts the zero offset from the unwrapped angle and scales by pole pairs.
  logic [A:0]          rev;
  logic [A:0]          mech;
  logic [A+1:0]        diff;
  logic signed [A+8:0] elec_full;

  always_comb begin
    rev       = TURN_V - {1'b0, angle_nxt};
    mech      = (rev > HALF_V) ? (rev - TURN_V) : rev;
    diff      = {1'b0, rev} - {2'b00, offset_r};
    elec_full = $signed({{7{diff[A+1]}}, diff}) * $signed({{(A+3){1'b0}}, pair_count_r});
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_if.request_transfer <= req_nxt;
      out_if.frame_accepted   <= acc_nxt;
      out_if.frame_rejected   <= rej_nxt;
      out_if.healthy          <= running_nxt && present_nxt && (age_nxt <= max_age_r);
      out_if.angle_code       <= angle_nxt;
      out_if.status_bits      <= status_nxt;
      out_if.mech_angle       <= $signed(mech);
      out_if.elec_pos         <= elec_full[A+6:0];
      out_if.sample_age       <= age_nxt;
      out_if.sample_count     <= good_nxt;
      out_if.error_count      <= bad_nxt;
    end
  end

  assign out_if.valid = out_valid_r;

  // A word may not be both accepted and rejected.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_if.frame_accepted && out_if.frame_rejected))
    else $error("result flags both accepted and rejected");

  // An accepted frame restarts the sample age.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_if.frame_accepted) |-> (out_if.sample_age == '0))
    else $error("accepted frame did not clear sample age");

  // A word moving out of the input register lands in the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("result word lost after update pass");

  // A launched transfer leaves the transfer marked busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_nxt) |=> busy_r)
    else $error("transfer launched without busy mark");

endmodule
